// ===== sv/bf3_pkg.sv =====
// Shared widths, codes and payload types for the 3x3 clipped box filter.
// No dependencies; every other file of the filter but bf3_ram imports this package.
package bf3_pkg;

   localparam int COMP_W = 16;   // one colour component
   localparam int POS_W  = 10;   // output row / column
   localparam int SIZE_W = 11;   // image size register
   localparam int COL_W  = 18;   // sum of up to three components
   localparam int SUM_W  = 20;   // sum of up to nine components
   localparam int CNT_W  = 4;    // neighbour count, 1..9

   localparam logic [SIZE_W-1:0] SIZE_RESET = 11'd512;

   localparam logic MODE_PIXEL = 1'b0;
   localparam logic MODE_DRAIN = 1'b1;

   // Component lanes: index 2 is red, 1 is green, 0 is blue.
   typedef logic [2:0][COMP_W-1:0] pixel_type;
   typedef logic [2:0][COL_W-1:0]  colsum_type;
   typedef logic [2:0][SUM_W-1:0]  winsum_type;

   typedef struct packed {
      logic [COMP_W-1:0] red;
      logic [COMP_W-1:0] green;
      logic [COMP_W-1:0] blue;
      logic [POS_W-1:0]  row;
      logic [POS_W-1:0]  col;
      logic              last;
   } rsp_item_type;

   // Up to two responses leave the pipeline per request.
   typedef struct packed {
      logic         valid_a;
      logic         valid_b;
      rsp_item_type item_a;
      rsp_item_type item_b;
   } rsp_pair_type;

endpackage

// ===== sv/box_filter_3x3_clipped.sv =====
// Path: an accepted request is registered into stage 1, then stage 2, then the response queue.
// Throughput: one request per cycle while the queue has room; each row but row 0 gives n
//   responses for n pixels (none for its first pixel, two for its last), which the
//   one-per-cycle response port keeps pace with. Input stalls when the four-entry response
//   queue cannot take a full pair. Reset (synchronous): counters, pipeline and queue empty,
//   image size 512; the two row stores keep whatever they hold and get no clearing pass.
module box_filter_3x3_clipped #(
   parameter int MAX_SIZE = 1024
) (
   input  logic                        clock,
   input  logic                        reset,
   // requests
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic                        req_mode,
   input  logic [bf3_pkg::COMP_W-1:0]  req_in_red,
   input  logic [bf3_pkg::COMP_W-1:0]  req_in_green,
   input  logic [bf3_pkg::COMP_W-1:0]  req_in_blue,
   // responses
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [bf3_pkg::COMP_W-1:0]  rsp_out_red,
   output logic [bf3_pkg::COMP_W-1:0]  rsp_out_green,
   output logic [bf3_pkg::COMP_W-1:0]  rsp_out_blue,
   output logic [bf3_pkg::POS_W-1:0]   rsp_out_row,
   output logic [bf3_pkg::POS_W-1:0]   rsp_out_col,
   output logic                        rsp_frame_last,
   // image size register
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [bf3_pkg::SIZE_W-1:0]  csr_image_size
);
   import bf3_pkg::*;

   localparam int AW = $clog2(MAX_SIZE);        // row store address
   localparam int NW = $clog2(MAX_SIZE + 1);    // holds the size itself
   localparam int CW = (NW > SIZE_W) ? NW : SIZE_W;

   // Per-request decisions taken at acceptance, carried into the read stage.
   typedef struct packed {
      logic top_ok;     // row above the middle row counts
      logic use_w0;     // oldest window column counts in response A
      logic use_cap;    // first drain: column 0 comes from the capture register
      logic use_csum;   // column just read counts in response A
      logic b_cols2;    // response B spans two columns
      logic valid_a;
      logic valid_b;
      logic last;
      logic cap;        // first pixel of the last row: capture column 0
   } s1_flags_type;

   // ---------------------------------------------------------------
   // Size register and frame counters
   // ---------------------------------------------------------------
   logic [SIZE_W-1:0] size_ff;
   logic [CW-1:0]     size_ext, n_clamp;
   logic [NW-1:0]     n_eff;
   logic [NW-1:0]     row_ff, row_in;
   logic [AW-1:0]     col_ff, col_in, drain_ff, drain_in;
   logic [NW-1:0]     col_p1, drain_p1;
   logic              csr_wr;

   assign csr_ready = 1'b1;
   assign csr_wr    = csr_valid && csr_ready;

   // Clamp the written size to 1..MAX_SIZE.
   always_comb begin
      size_ext = CW'(size_ff);
      if (size_ext == '0) begin
         n_clamp = CW'(1);
      end else if (size_ext > CW'(MAX_SIZE)) begin
         n_clamp = CW'(MAX_SIZE);
      end else begin
         n_clamp = size_ext;
      end
      n_eff = NW'(n_clamp);
   end

   // ---------------------------------------------------------------
   // Acceptance and classification
   // ---------------------------------------------------------------
   logic          advance, acc, is_pix, is_drn, pix_ok, drn_ok;
   s1_flags_type  flags_in;
   logic [POS_W-1:0] row_out_in, col_a_in, col_b_in;
   logic [AW-1:0] rd_addr;
   pixel_type     in_px;

   assign in_px     = {req_in_red, req_in_green, req_in_blue};
   assign req_stall = !advance;
   assign acc       = req_valid && advance;

   always_comb begin
      is_pix   = (req_mode == MODE_PIXEL);
      is_drn   = (req_mode == MODE_DRAIN);
      col_p1   = NW'(col_ff) + NW'(1);
      drain_p1 = NW'(drain_ff) + NW'(1);
      // Extra pixels after the last row and early drains are dropped.
      pix_ok   = is_pix && (row_ff < n_eff) && (NW'(col_ff) < n_eff);
      drn_ok   = is_drn && (row_ff >= n_eff) && (NW'(drain_ff) < n_eff);

      flags_in.top_ok   = is_pix ? (row_ff >= NW'(2)) : (n_eff >= NW'(2));
      flags_in.use_w0   = is_pix ? (NW'(col_ff) >= NW'(2)) : (NW'(drain_ff) >= NW'(1));
      flags_in.use_cap  = is_drn && (drain_ff == '0);
      flags_in.use_csum = is_pix || (drain_p1 < n_eff);
      flags_in.b_cols2  = (NW'(col_ff) >= NW'(1));
      flags_in.valid_a  = is_pix ? ((row_ff >= NW'(1)) && (NW'(col_ff) >= NW'(1))) : 1'b1;
      flags_in.valid_b  = is_pix && (row_ff >= NW'(1)) && (col_p1 == n_eff);
      flags_in.last     = is_drn && (drain_p1 == n_eff);
      flags_in.cap      = is_pix && (col_ff == '0) && (row_ff == n_eff - NW'(1));

      row_out_in = is_pix ? POS_W'(row_ff - NW'(1)) : POS_W'(n_eff - NW'(1));
      col_a_in   = is_pix ? POS_W'(NW'(col_ff) - NW'(1)) : POS_W'(drain_ff);
      col_b_in   = POS_W'(col_ff);
      // A drain reads the column to the right of its own; the rest is windowed.
      rd_addr    = is_pix ? col_ff : AW'(drain_p1);
   end

   always_comb begin
      row_in   = row_ff;
      col_in   = col_ff;
      drain_in = drain_ff;
      if (csr_wr) begin
         // Restart the frame; the stores keep their contents.
         row_in   = '0;
         col_in   = '0;
         drain_in = '0;
      end else if (acc && pix_ok) begin
         if (col_p1 >= n_eff) begin
            col_in = '0;
            row_in = row_ff + NW'(1);
         end else begin
            col_in = AW'(col_p1);
         end
      end else if (acc && drn_ok) begin
         if (drain_p1 == n_eff) begin
            row_in   = '0;
            col_in   = '0;
            drain_in = '0;
         end else begin
            drain_in = AW'(drain_p1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff  <= SIZE_RESET;
         row_ff   <= '0;
         col_ff   <= '0;
         drain_ff <= '0;
      end else begin
         if (csr_wr) begin
            size_ff <= csr_image_size;
         end
         row_ff   <= row_in;
         col_ff   <= col_in;
         drain_ff <= drain_in;
      end
   end

   // ---------------------------------------------------------------
   // Stage 1: row store read data arrives
   // ---------------------------------------------------------------
   logic             s1_pix_ff, s1_drn_ff;
   s1_flags_type     s1_flags_ff;
   pixel_type        s1_rgb_ff;
   logic [AW-1:0]    s1_addr_ff;
   logic [POS_W-1:0] s1_row_ff, s1_col_a_ff, s1_col_b_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_pix_ff <= 1'b0;
         s1_drn_ff <= 1'b0;
      end else if (advance) begin
         s1_pix_ff <= acc && pix_ok;
         s1_drn_ff <= acc && drn_ok;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_flags_ff <= flags_in;
         s1_rgb_ff   <= in_px;
         s1_addr_ff  <= col_ff;
         s1_row_ff   <= row_out_in;
         s1_col_a_ff <= col_a_in;
         s1_col_b_ff <= col_b_in;
      end
   end

   // Row stores: older holds row r-2, newer holds row r-1 while row r arrives.
   pixel_type older_q, newer_q;
   logic      wr_en;

   assign wr_en = advance && s1_pix_ff;

   // Forward the write of the request ahead when the next request reads the same column.
   logic      fwd_ff;
   pixel_type fwd_old_ff, fwd_new_ff;
   pixel_type top_px, mid_px, bot_px;

   assign top_px = fwd_ff ? fwd_old_ff : older_q;
   assign mid_px = fwd_ff ? fwd_new_ff : newer_q;
   assign bot_px = s1_pix_ff ? s1_rgb_ff : '0;

   bf3_ram #(
      .WIDTH (3 * COMP_W),
      .DEPTH (MAX_SIZE)
   ) u_older_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (s1_addr_ff),
      .wr_data (mid_px),
      .rd_en   (advance),
      .rd_addr (rd_addr),
      .rd_data (older_q)
   );

   bf3_ram #(
      .WIDTH (3 * COMP_W),
      .DEPTH (MAX_SIZE)
   ) u_newer_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (s1_addr_ff),
      .wr_data (s1_rgb_ff),
      .rd_en   (advance),
      .rd_addr (rd_addr),
      .rd_data (newer_q)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_ff <= 1'b0;
      end else if (advance) begin
         fwd_ff <= s1_pix_ff && (rd_addr == s1_addr_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         fwd_old_ff <= mid_px;
         fwd_new_ff <= s1_rgb_ff;
      end
   end

   // Window of column sums: win0 is two columns back, win1 one column back.
   // cap holds the drain-time sum of column 0, taken from the first pixel of the last row.
   colsum_type win0_ff, win1_ff, cap_ff;
   colsum_type csum, term0, term1, term2, cap_in;
   winsum_type sum_a, sum_b;
   logic [CNT_W-1:0] rows, cols_a, cols_b, cnt_a, cnt_b;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         csum[k]   = COL_W'(mid_px[k]) + COL_W'(bot_px[k])
                   + (s1_flags_ff.top_ok ? COL_W'(top_px[k]) : '0);
         term0[k]  = s1_flags_ff.use_w0 ? win0_ff[k] : '0;
         term1[k]  = s1_flags_ff.use_cap ? cap_ff[k] : win1_ff[k];
         term2[k]  = s1_flags_ff.use_csum ? csum[k] : '0;
         sum_a[k]  = SUM_W'(term0[k]) + SUM_W'(term1[k]) + SUM_W'(term2[k]);
         sum_b[k]  = SUM_W'(s1_flags_ff.b_cols2 ? win1_ff[k] : '0) + SUM_W'(csum[k]);
         // After the write, column 0 holds the middle row above the new pixel.
         cap_in[k] = COL_W'(s1_rgb_ff[k]) + ((n_eff >= NW'(2)) ? COL_W'(mid_px[k]) : '0);
      end
      // Pixels count the row below; drains do not.
      rows   = CNT_W'(1) + CNT_W'(s1_flags_ff.top_ok) + CNT_W'(s1_pix_ff);
      cols_a = CNT_W'(1) + CNT_W'(s1_flags_ff.use_w0) + CNT_W'(s1_flags_ff.use_csum);
      cols_b = CNT_W'(1) + CNT_W'(s1_flags_ff.b_cols2);
      cnt_a  = cols_a * rows;
      cnt_b  = cols_b * rows;
   end

   always_ff @(posedge clock) begin
      if (advance && (s1_pix_ff || s1_drn_ff)) begin
         win0_ff <= term1;
         win1_ff <= csum;
      end
      if (advance && s1_pix_ff && s1_flags_ff.cap) begin
         cap_ff <= cap_in;
      end
   end

   // ---------------------------------------------------------------
   // Stage 2: sums and counts; divide on the way into the queue
   // ---------------------------------------------------------------
   logic             s2_va_ff, s2_vb_ff;
   winsum_type       s2_sum_a_ff, s2_sum_b_ff;
   logic [CNT_W-1:0] s2_cnt_a_ff, s2_cnt_b_ff;
   logic [POS_W-1:0] s2_row_ff, s2_col_a_ff, s2_col_b_ff;
   logic             s2_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_va_ff <= 1'b0;
         s2_vb_ff <= 1'b0;
      end else if (advance) begin
         s2_va_ff <= (s1_pix_ff || s1_drn_ff) && s1_flags_ff.valid_a;
         s2_vb_ff <= s1_pix_ff && s1_flags_ff.valid_b;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s2_sum_a_ff <= sum_a;
         s2_sum_b_ff <= sum_b;
         s2_cnt_a_ff <= cnt_a;
         s2_cnt_b_ff <= cnt_b;
         s2_row_ff   <= s1_row_ff;
         s2_col_a_ff <= s1_col_a_ff;
         s2_col_b_ff <= s1_col_b_ff;
         s2_last_ff  <= s1_drn_ff && s1_flags_ff.last;
      end
   end

   pixel_type    mean_a, mean_b;
   rsp_pair_type push;
   rsp_item_type head;

   for (genvar k = 0; k < 3; k++) begin : g_lane
      bf3_mean_div u_div_a (
         .total (s2_sum_a_ff[k]),
         .cnt   (s2_cnt_a_ff),
         .mean  (mean_a[k])
      );
      bf3_mean_div u_div_b (
         .total (s2_sum_b_ff[k]),
         .cnt   (s2_cnt_b_ff),
         .mean  (mean_b[k])
      );
   end

   always_comb begin
      push.valid_a      = s2_va_ff;
      push.valid_b      = s2_vb_ff;
      push.item_a.red   = mean_a[2];
      push.item_a.green = mean_a[1];
      push.item_a.blue  = mean_a[0];
      push.item_a.row   = s2_row_ff;
      push.item_a.col   = s2_col_a_ff;
      push.item_a.last  = s2_last_ff;
      // The row-end response never closes the frame.
      push.item_b.red   = mean_b[2];
      push.item_b.green = mean_b[1];
      push.item_b.blue  = mean_b[0];
      push.item_b.row   = s2_row_ff;
      push.item_b.col   = s2_col_b_ff;
      push.item_b.last  = 1'b0;
   end

   // The whole pipeline moves together whenever the queue has room for a pair.
   bf3_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push_en   (advance),
      .push      (push),
      .room      (advance),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .head      (head)
   );

   assign rsp_out_red    = head.red;
   assign rsp_out_green  = head.green;
   assign rsp_out_blue   = head.blue;
   assign rsp_out_row    = head.row;
   assign rsp_out_col    = head.col;
   assign rsp_frame_last = head.last;

endmodule

// ===== sv/bf3_ram.sv =====
// Generic single-write, single-read synchronous RAM with a registered read port.
// No dependencies.
module bf3_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/bf3_mean_div.sv =====
// Truncated mean of a neighbourhood sum over a count of 1, 2, 3, 4, 6 or 9.
// Depends on bf3_pkg; a shift plus one multiply by a reciprocal of 1, 3 or 9.
module bf3_mean_div (
   input  logic [bf3_pkg::SUM_W-1:0]  total,
   input  logic [bf3_pkg::CNT_W-1:0]  cnt,
   output logic [bf3_pkg::COMP_W-1:0] mean
);
   import bf3_pkg::*;

   localparam int RECIP_SHIFT = 24;
   localparam int RW          = RECIP_SHIFT + 1;
   localparam int PW          = SUM_W + RW;
   // Rounded-up reciprocals; the error stays below one for any SUM_W-bit sum.
   localparam logic [RW-1:0] RECIP_ONE   = RW'(2 ** RECIP_SHIFT);
   localparam logic [RW-1:0] RECIP_THIRD = RW'((2 ** RECIP_SHIFT + 2) / 3);
   localparam logic [RW-1:0] RECIP_NINTH = RW'((2 ** RECIP_SHIFT + 8) / 9);

   logic [1:0]       shift_amt;
   logic [RW-1:0]    recip;
   logic [SUM_W-1:0] shifted;
   logic [PW-1:0]    prod;

   always_comb begin
      case (cnt)
         4'd2: begin
            shift_amt = 2'd1;
            recip     = RECIP_ONE;
         end
         4'd3: begin
            shift_amt = 2'd0;
            recip     = RECIP_THIRD;
         end
         4'd4: begin
            shift_amt = 2'd2;
            recip     = RECIP_ONE;
         end
         4'd6: begin
            shift_amt = 2'd1;
            recip     = RECIP_THIRD;
         end
         4'd9: begin
            shift_amt = 2'd0;
            recip     = RECIP_NINTH;
         end
         default: begin
            shift_amt = 2'd0;
            recip     = RECIP_ONE;
         end
      endcase
      shifted = total >> shift_amt;
      prod    = PW'(shifted) * PW'(recip);
      mean    = COMP_W'(prod >> RECIP_SHIFT);
   end

endmodule

// ===== sv/bf3_rsp_fifo.sv =====
// Response queue: takes up to two responses per cycle, hands out one per cycle.
// Depends on bf3_pkg for the response types.
module bf3_rsp_fifo (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push_en,
   input  bf3_pkg::rsp_pair_type push,
   output logic                  room,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output bf3_pkg::rsp_item_type head
);
   import bf3_pkg::*;

   localparam int DEPTH = 4;
   localparam int PW    = $clog2(DEPTH);
   localparam int CNTW  = $clog2(DEPTH + 1);

   rsp_item_type    entry_ff [DEPTH];
   logic [PW-1:0]   wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in, b_ptr;
   logic [CNTW-1:0] count_ff, count_in;
   logic            push_a, push_b, pop;

   always_comb begin
      push_a    = push_en && push.valid_a;
      push_b    = push_en && push.valid_b;
      pop       = rsp_valid && !rsp_stall;
      b_ptr     = push_a ? wr_ptr_ff + PW'(1) : wr_ptr_ff;
      wr_ptr_in = wr_ptr_ff + PW'(push_a) + PW'(push_b);
      rd_ptr_in = pop ? rd_ptr_ff + PW'(1) : rd_ptr_ff;
      count_in  = count_ff + CNTW'(push_a) + CNTW'(push_b) - CNTW'(pop);
   end

   assign rsp_valid = (count_ff != '0);
   // Room for a full pair, whatever leaves this cycle.
   assign room      = (count_ff <= CNTW'(DEPTH - 2));
   assign head      = entry_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_a) begin
         entry_ff[wr_ptr_ff] <= push.item_a;
      end
      if (push_b) begin
         entry_ff[b_ptr] <= push.item_b;
      end
   end

endmodule

// ===== test/box_filter_3x3_clipped_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the 3x3 clipped box filter: directed and random frames.
// Depends on bf3_pkg and box_filter_3x3_clipped; predicts every response in-bench.
module box_filter_3x3_clipped_test;
   import bf3_pkg::*;

   localparam int MAX_SIZE      = 1024;
   localparam int RANDOM_ITEMS  = 500;
   // Enough cycles for the two-stage pipeline and the response queue to empty.
   localparam int SETTLE_CYCLES = 8;
   localparam int DRAIN_LIMIT   = 200000;
   // The limit lies well above the slowest correct run.
   localparam longint TIMEOUT_NS = 64'd80_000_000;

   typedef logic [3*COMP_W-1:0] pixel_word_type;   // red, green, blue from the top

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_stall;
   logic                req_mode;
   logic [COMP_W-1:0]   req_in_red;
   logic [COMP_W-1:0]   req_in_green;
   logic [COMP_W-1:0]   req_in_blue;
   logic                rsp_valid;
   logic                rsp_stall;
   logic [COMP_W-1:0]   rsp_out_red;
   logic [COMP_W-1:0]   rsp_out_green;
   logic [COMP_W-1:0]   rsp_out_blue;
   logic [POS_W-1:0]    rsp_out_row;
   logic [POS_W-1:0]    rsp_out_col;
   logic                rsp_frame_last;
   logic                csr_valid;
   logic                csr_ready;
   logic [SIZE_W-1:0]   csr_image_size;

   // Predicted filter state, kept alongside the block.
   pixel_word_type      older_row [MAX_SIZE];
   pixel_word_type      newer_row [MAX_SIZE];
   pixel_word_type      window_cols [6];
   int unsigned         pred_row;
   int unsigned         pred_col;
   int unsigned         pred_drain;
   logic [SIZE_W-1:0]   size_reg;

   // Running sums for the neighbourhood currently being averaged.
   int unsigned         sum_red;
   int unsigned         sum_green;
   int unsigned         sum_blue;
   int unsigned         sum_count;

   rsp_item_type        expected_pixels [$];

   int unsigned         fail_count;
   int unsigned         requests_sent;
   int unsigned         responses_checked;
   int unsigned         frames_done;
   int unsigned         sizes_written;
   bit                  quiet_phase;   // set: no gaps and no stalls on either side

   box_filter_3x3_clipped #(
      .MAX_SIZE(MAX_SIZE)
   ) i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_mode       (req_mode),
      .req_in_red     (req_in_red),
      .req_in_green   (req_in_green),
      .req_in_blue    (req_in_blue),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_out_red    (rsp_out_red),
      .rsp_out_green  (rsp_out_green),
      .rsp_out_blue   (rsp_out_blue),
      .rsp_out_row    (rsp_out_row),
      .rsp_out_col    (rsp_out_col),
      .rsp_frame_last (rsp_frame_last),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_image_size (csr_image_size)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // ------------------------------------------------------------------
   // Prediction
   // ------------------------------------------------------------------

   // Clamp the register the way the block does: 0 acts as 1, anything above the
   // row store depth acts as the depth.
   function automatic int unsigned active_size();
      if (size_reg == 0) return 1;
      if (size_reg > MAX_SIZE) return MAX_SIZE;
      return size_reg;
   endfunction

   function automatic void clear_sums();
      sum_red   = 0;
      sum_green = 0;
      sum_blue  = 0;
      sum_count = 0;
   endfunction

   function automatic void add_pixel(pixel_word_type p);
      sum_red   += p[3*COMP_W-1:2*COMP_W];
      sum_green += p[2*COMP_W-1:COMP_W];
      sum_blue  += p[COMP_W-1:0];
      sum_count++;
   endfunction

   // One window column: the middle pixel always counts, top and bottom only
   // where they lie inside the image.
   function automatic void add_column(pixel_word_type top, pixel_word_type mid,
                                      pixel_word_type bot, bit top_ok, bit bot_ok);
      add_pixel(mid);
      if (top_ok) add_pixel(top);
      if (bot_ok) add_pixel(bot);
   endfunction

   function automatic void push_mean(int unsigned row, int unsigned col, bit last);
      rsp_item_type item;
      int unsigned  divisor;
      divisor    = (sum_count == 0) ? 1 : sum_count;
      item.red   = COMP_W'(sum_red / divisor);
      item.green = COMP_W'(sum_green / divisor);
      item.blue  = COMP_W'(sum_blue / divisor);
      item.row   = POS_W'(row);
      item.col   = POS_W'(col);
      item.last  = last;
      expected_pixels.push_back(item);
   endfunction

   function automatic void restart_frame(logic [SIZE_W-1:0] value);
      size_reg   = value;
      pred_row   = 0;
      pred_col   = 0;
      pred_drain = 0;
   endfunction

   // Work out the responses that one accepted request causes and queue them.
   function automatic void predict_request(logic mode, pixel_word_type px);
      int unsigned    n;
      int unsigned    r;
      int unsigned    c;
      int unsigned    d;
      int unsigned    lo;
      int unsigned    hi;
      int unsigned    x;
      pixel_word_type top;
      pixel_word_type mid;
      bit             top_ok;
      n = active_size();
      if (mode == MODE_PIXEL) begin
         r = pred_row;
         c = pred_col;
         // Drop extra pixels while waiting for drain requests.
         if (r >= n || c >= n) return;
         top          = older_row[c];
         mid          = newer_row[c];
         older_row[c] = mid;
         newer_row[c] = px;
         if (r >= 1) begin
            top_ok = (r >= 2);
            if (c >= 1) begin
               clear_sums();
               if (c >= 2)
                  add_column(window_cols[0], window_cols[1], window_cols[2], top_ok, 1'b1);
               add_column(window_cols[3], window_cols[4], window_cols[5], top_ok, 1'b1);
               add_column(top, mid, px, top_ok, 1'b1);
               push_mean(r - 1, c - 1, 1'b0);
            end
            // Row end: the right-edge output of the row above leaves too.
            if (c + 1 == n) begin
               clear_sums();
               if (c >= 1)
                  add_column(window_cols[3], window_cols[4], window_cols[5], top_ok, 1'b1);
               add_column(top, mid, px, top_ok, 1'b1);
               push_mean(r - 1, c, 1'b0);
            end
         end
         window_cols[0] = window_cols[3];
         window_cols[1] = window_cols[4];
         window_cols[2] = window_cols[5];
         window_cols[3] = top;
         window_cols[4] = mid;
         window_cols[5] = px;
         if (c + 1 >= n) begin
            pred_col = 0;
            pred_row = r + 1;
         end else begin
            pred_col = c + 1;
         end
      end else begin
         d = pred_drain;
         // Drop drains that come before the last row is complete.
         if (pred_row < n || d >= n) return;
         lo = (d >= 1) ? d - 1 : 0;
         hi = (d + 1 < n) ? d + 1 : d;
         clear_sums();
         for (x = lo; x <= hi; x++)
            add_column(older_row[x], newer_row[x], '0, n >= 2, 1'b0);
         push_mean(n - 1, d, d + 1 == n);
         if (d + 1 == n) restart_frame(size_reg);
         else pred_drain = d + 1;
      end
   endfunction

   // ------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------

   // Mostly back to back, sometimes a short gap, rarely a long pause.
   function automatic int unsigned pick_gap();
      int unsigned roll;
      if (quiet_phase) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 60) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      if (roll < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // Bias towards the extremes so that saturated sums turn up often.
   function automatic logic [COMP_W-1:0] rand_comp();
      int unsigned roll;
      roll = $urandom_range(0, 9);
      if (roll == 0) return '0;
      if (roll == 1) return '1;
      return COMP_W'($urandom);
   endfunction

   // Present one request and hold it until accepted. The valid is left high so
   // that a following request without a gap keeps it high throughout.
   task automatic send_request(logic mode, logic [COMP_W-1:0] red, green, blue);
      int unsigned gap;
      gap = pick_gap();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_mode     <= mode;
      req_in_red   <= red;
      req_in_green <= green;
      req_in_blue  <= blue;
      do @(posedge clock); while (req_stall);
      predict_request(mode, {red, green, blue});
      requests_sent++;
   endtask

   task automatic send_pixels(int unsigned count);
      repeat (count) send_request(MODE_PIXEL, rand_comp(), rand_comp(), rand_comp());
   endtask

   // Drain payloads are unused; randomise them anyway.
   task automatic send_drains(int unsigned count);
      repeat (count) send_request(MODE_DRAIN, rand_comp(), rand_comp(), rand_comp());
   endtask

   // Drop valid, wait for every expected response, then let the pipeline settle
   // in case the last requests caused none.
   task automatic wait_idle();
      int unsigned waited;
      req_valid <= 1'b0;
      waited = 0;
      while (expected_pixels.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      if (expected_pixels.size() != 0) begin
         $error("%0d expected responses never arrived", expected_pixels.size());
         fail_count++;
         expected_pixels.delete();
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Any write restarts the frame; the row stores keep their contents.
   task automatic write_image_size(logic [SIZE_W-1:0] value);
      wait_idle();
      csr_valid      <= 1'b1;
      csr_image_size <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      restart_frame(value);
      sizes_written++;
   endtask

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // Reset size is 512: fill row 0 and six pixels of row 1, so outputs only
   // appear if the row length really is 512.
   task automatic test_reset_size();
      send_pixels(512 + 6);
      wait_idle();
   endtask

   // Full-scale and zero components; nine full-scale reds exercise the widest sum.
   task automatic test_component_extremes();
      int k;
      quiet_phase = 1'b1;
      write_image_size(SIZE_W'(3));
      for (k = 0; k < 9; k++)
         send_request(MODE_PIXEL, '1, '0, (k % 2 != 0) ? '1 : '0);
      send_drains(3);
      quiet_phase = 1'b0;
   endtask

   // Size 0 behaves as 1; sizes 1 and 2 leave almost every neighbour outside.
   task automatic test_tiny_sizes();
      write_image_size(SIZE_W'(0));
      send_pixels(1);
      send_drains(1);
      write_image_size(SIZE_W'(1));
      send_pixels(1);
      send_drains(1);
      write_image_size(SIZE_W'(2));
      send_pixels(4);
      send_drains(2);
   endtask

   // An early drain, an extra pixel while waiting for drains, and a drain
   // after the frame has ended must all produce nothing.
   task automatic test_ignored_items();
      write_image_size(SIZE_W'(2));
      send_drains(1);
      send_pixels(4);
      send_pixels(1);
      send_drains(2);
      send_drains(1);
   endtask

   // Rewrite the size part-way through a frame, then again while the block
   // waits for drains; each write starts a fresh frame.
   task automatic test_restart();
      write_image_size(SIZE_W'(4));
      send_pixels(6);
      write_image_size(SIZE_W'(3));
      send_pixels(9);
      write_image_size(SIZE_W'(3));
      send_pixels(9);
      send_drains(3);
   endtask

   // Largest row: two full rows of 1024 reach column 1023 and its row end.
   // Then the top register value, which must clamp to 1024.
   task automatic test_large_sizes();
      write_image_size(SIZE_W'(MAX_SIZE));
      send_pixels(2 * MAX_SIZE);
      write_image_size('1);
      send_pixels(MAX_SIZE + 3);
   endtask

   // Mostly complete frames of small sizes with random content; the rest are
   // early drains, extra pixels, and frames cut short by a size write.
   task automatic test_random_frames();
      int unsigned counted;
      int unsigned roll;
      int unsigned size;
      int unsigned side;
      int unsigned total;
      int unsigned stop_at;
      bit          aborted;
      counted = 0;
      while (counted < RANDOM_ITEMS) begin
         roll = $urandom_range(0, 99);
         if (roll < 5) size = 0;
         else if (roll < 70) size = $urandom_range(1, 8);
         else if (roll < 95) size = $urandom_range(9, 20);
         else size = $urandom_range(21, 40);
         side  = (size == 0) ? 1 : size;
         total = side * side;
         quiet_phase = ($urandom_range(0, 4) == 0);
         write_image_size(SIZE_W'(size));
         roll    = $urandom_range(0, 99);
         aborted = (roll >= 10 && roll < 20);
         if (roll < 10) send_drains($urandom_range(1, 3));
         stop_at = aborted ? $urandom_range(0, total) : total;
         send_pixels(stop_at);
         counted += stop_at;
         if (!aborted) begin
            if (roll >= 20 && roll < 30) send_pixels($urandom_range(1, 3));
            send_drains(side);
            counted += side;
         end
      end
      quiet_phase = 1'b0;
   endtask

   // ------------------------------------------------------------------
   // Response checking and back-pressure
   // ------------------------------------------------------------------

   function automatic void check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         $error("%s mismatch: expected %0d, actual %0d", name, want, got);
         fail_count++;
      end
   endfunction

   // Compare each accepted response with the oldest expectation, and drive
   // random stall runs for the next cycles.
   initial begin : response_checker
      int unsigned  stall_left;
      rsp_item_type want;
      stall_left = 0;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            if (expected_pixels.size() == 0) begin
               $error("unexpected response at row %0d col %0d", rsp_out_row, rsp_out_col);
               fail_count++;
            end else begin
               want = expected_pixels.pop_front();
               check_field("out_red",    want.red,   rsp_out_red);
               check_field("out_green",  want.green, rsp_out_green);
               check_field("out_blue",   want.blue,  rsp_out_blue);
               check_field("out_row",    want.row,   rsp_out_row);
               check_field("out_col",    want.col,   rsp_out_col);
               check_field("frame_last", want.last,  rsp_frame_last);
               responses_checked++;
               if (want.last) frames_done++;
            end
         end
         if (stall_left != 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else begin
            rsp_stall <= 1'b0;
            stall_left = pick_gap();
         end
      end
   end

   // ------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------

   initial begin
      int k;
      fail_count        = 0;
      requests_sent     = 0;
      responses_checked = 0;
      frames_done       = 0;
      sizes_written     = 0;
      quiet_phase       = 1'b0;
      // Predictor state after reset; the stores start at zero here, but no
      // unwritten entry ever reaches a response.
      for (k = 0; k < MAX_SIZE; k++) begin
         older_row[k] = '0;
         newer_row[k] = '0;
      end
      for (k = 0; k < 6; k++) window_cols[k] = '0;
      restart_frame(SIZE_RESET);

      reset          <= 1'b1;
      req_valid      <= 1'b0;
      req_mode       <= MODE_PIXEL;
      req_in_red     <= '0;
      req_in_green   <= '0;
      req_in_blue    <= '0;
      csr_valid      <= 1'b0;
      csr_image_size <= SIZE_RESET;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_size();
      test_component_extremes();
      test_tiny_sizes();
      test_ignored_items();
      test_restart();
      test_large_sizes();
      test_random_frames();
      wait_idle();

      $display("Sent %0d requests over %0d size writes (0 to 2047, clamped at both ends);",
               requests_sent, sizes_written);
      $display("checked %0d responses, %0d complete frames.", responses_checked, frames_done);
      if (fail_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   // Hard limit on the run in case a handshake never completes.
   initial begin
      #(TIMEOUT_NS);
      $display("Timed out waiting for the filter");
      $display("== FAIL ==");
      $finish;
   end

endmodule

// ===== files.f =====
sv/bf3_pkg.sv
sv/bf3_ram.sv
sv/bf3_mean_div.sv
sv/bf3_rsp_fifo.sv
sv/box_filter_3x3_clipped.sv
test/box_filter_3x3_clipped_test.sv
